FILE: sv/decimal_length_prefix_deframer_macros.svh
// Assertion macros for the decimal length-prefix deframer.
// Depends on nothing; included by the top level only.
`ifndef DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dlpd_pkg.sv
// Types and constants for the decimal length-prefix deframer.
// Depends on nothing.
package dlpd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 14;
    localparam int PROD_W = LEN_W + 4;   // room for length * 10 + 9

    localparam logic [LEN_W-1:0]  LEN_MAX   = 14'd16383;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

endpackage

FILE: sv/decimal_length_prefix_deframer.sv
// Top level of the decimal length-prefix deframer.
// Depends on dlpd_pkg and decimal_length_prefix_deframer_macros.svh.
//
// The block takes one stream byte per transfer and splits the stream into
// frames: HEADER_DIGITS ASCII decimal digits, most significant first, give
// the body length, and that many body bytes follow. Each body byte leaves as
// one result transfer of kind body, with packet_end set on the final one. A
// header that reads zero gives one empty-packet result on its final digit.
// Header bytes other than the final one give no result. A non-digit anywhere
// in a header turns the final header byte into a header-error result, and
// from then on every byte gives a header-error result until reset. Lengths
// above 16383 (only possible with more than four digits) saturate at 16383.
// Rate: one byte per clock cycle while in_stall is low. The whole per-byte
// update (a digit check, a multiply by ten done as two shifts and an add, and
// the body countdown) is combinational between the input port and the result
// register, so the result of a byte appears in the cycle after its transfer.
// in_stall rises only while the result register is full and out_stall holds
// it; a byte that gives no result still waits for that register to drain.
module decimal_length_prefix_deframer #(
    parameter int HEADER_DIGITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dlpd_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  result_kind,
    output logic [dlpd_pkg::BYTE_W-1:0] body_byte,
    output logic                        packet_end
);

`include "decimal_length_prefix_deframer_macros.svh"

    localparam int DIG_W = $clog2(HEADER_DIGITS + 1);
    localparam logic [DIG_W-1:0] DIGITS_INIT = DIG_W'(HEADER_DIGITS);

    // Frame state
    logic                        in_body_reg,      in_body_next;
    logic [DIG_W-1:0]            digits_left_reg,  digits_left_next;
    logic [dlpd_pkg::LEN_W-1:0]  length_accum_reg, length_accum_next;
    logic                        bad_digit_reg,    bad_digit_next;
    logic [dlpd_pkg::LEN_W-1:0]  body_left_reg,    body_left_next;
    logic                        sticky_error_reg, sticky_error_next;

    // Result register
    logic                        out_valid_reg,    out_valid_next;
    dlpd_pkg::kind_t             kind_reg,         kind_next;
    logic [dlpd_pkg::BYTE_W-1:0] body_byte_reg,    body_byte_next;
    logic                        packet_end_reg,   packet_end_next;

    logic                        in_fire;
    logic                        out_fire;
    logic                        emit;
    logic                        is_digit;
    logic [3:0]                  digit_val;
    logic [dlpd_pkg::PROD_W-1:0] accum_sum;
    logic [dlpd_pkg::LEN_W-1:0]  accum_sat;
    logic [dlpd_pkg::LEN_W-1:0]  body_dec;
    logic [DIG_W-1:0]            digits_dec;

    // Hold input while a result waits downstream.
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign body_byte   = body_byte_reg;
    assign packet_end  = packet_end_reg;

    // Digit check and length * 10 + digit, saturated.
    assign is_digit  = (in_byte >= dlpd_pkg::CHAR_ZERO) && (in_byte <= dlpd_pkg::CHAR_NINE);
    assign digit_val = 4'(in_byte - dlpd_pkg::CHAR_ZERO);
    assign accum_sum = ({4'b0, length_accum_reg} << 3)
                     + ({4'b0, length_accum_reg} << 1)
                     + {{(dlpd_pkg::PROD_W - 4){1'b0}}, digit_val};
    assign accum_sat = (accum_sum > {4'b0, dlpd_pkg::LEN_MAX})
                     ? dlpd_pkg::LEN_MAX : accum_sum[dlpd_pkg::LEN_W-1:0];

    assign body_dec   = (body_left_reg != '0) ? body_left_reg - 1'b1 : body_left_reg;
    assign digits_dec = (digits_left_reg != '0) ? digits_left_reg - 1'b1 : digits_left_reg;

    always_comb
    begin
        in_body_next      = in_body_reg;
        digits_left_next  = digits_left_reg;
        length_accum_next = length_accum_reg;
        bad_digit_next    = bad_digit_reg;
        body_left_next    = body_left_reg;
        sticky_error_next = sticky_error_reg;
        emit              = 1'b0;
        kind_next         = dlpd_pkg::KIND_ERROR;
        body_byte_next    = '0;
        packet_end_next   = 1'b0;

        if (in_fire)
        begin
            priority if (sticky_error_reg)
            begin
                // Stay in error: every byte reports it.
                emit = 1'b1;
            end
            else if (in_body_reg)
            begin
                emit            = 1'b1;
                kind_next       = dlpd_pkg::KIND_BODY;
                body_byte_next  = in_byte;
                packet_end_next = (body_left_reg <= dlpd_pkg::LEN_W'(1));
                body_left_next  = body_dec;
                if (body_dec == '0)
                begin
                    in_body_next      = 1'b0;
                    digits_left_next  = DIGITS_INIT;
                    length_accum_next = '0;
                    bad_digit_next    = 1'b0;
                end
            end
            else
            begin
                // Header byte: mark bad digits, fold good ones into the length.
                if (is_digit)
                    length_accum_next = accum_sat;
                else
                    bad_digit_next = 1'b1;
                digits_left_next = digits_dec;

                if (digits_dec == '0)
                begin
                    priority if (bad_digit_next)
                    begin
                        sticky_error_next = 1'b1;
                        emit              = 1'b1;
                    end
                    else if (length_accum_next == '0)
                    begin
                        // Empty packet: restart the header at once.
                        emit              = 1'b1;
                        kind_next         = dlpd_pkg::KIND_EMPTY;
                        packet_end_next   = 1'b1;
                        digits_left_next  = DIGITS_INIT;
                        length_accum_next = '0;
                        bad_digit_next    = 1'b0;
                    end
                    else
                    begin
                        body_left_next    = length_accum_next;
                        in_body_next      = 1'b1;
                        digits_left_next  = DIGITS_INIT;
                        length_accum_next = '0;
                    end
                end
            end
        end

        // Load a new result, or drop the old one once it is taken.
        if (emit)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg      <= 1'b0;
            digits_left_reg  <= DIGITS_INIT;
            length_accum_reg <= '0;
            bad_digit_reg    <= 1'b0;
            body_left_reg    <= '0;
            sticky_error_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_body_reg      <= in_body_next;
            digits_left_reg  <= digits_left_next;
            length_accum_reg <= length_accum_next;
            bad_digit_reg    <= bad_digit_next;
            body_left_reg    <= body_left_next;
            sticky_error_reg <= sticky_error_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload: loaded only with a new result.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg       <= kind_next;
            body_byte_reg  <= body_byte_next;
            packet_end_reg <= packet_end_next;
        end
    end

    // Assertions
    `DLPD_ASSERT_NEXT(a_sticky_holds, clk, rst_n, sticky_error_reg, sticky_error_reg,
        "sticky error cleared without reset")
    `DLPD_ASSERT_NOW(a_body_nonzero, clk, rst_n, in_body_reg, body_left_reg != '0,
        "body state with no bytes left")
    `DLPD_ASSERT_NOW(a_header_count, clk, rst_n, !in_body_reg && !sticky_error_reg,
        digits_left_reg != '0,
        "header collection with no digits left")
    `DLPD_ASSERT_NOW(a_empty_ends, clk, rst_n,
        out_valid_reg && kind_reg == dlpd_pkg::KIND_EMPTY,
        packet_end_reg && body_byte_reg == '0,
        "empty packet without packet end")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for decimal_length_prefix_deframer.
// Depends on dlpd_pkg and the deframer RTL; holds a frame-tracking scoreboard
// class, stimulus tasks and random valid/stall idling on both sides.
module tb_top;

    import dlpd_pkg::*;

    localparam int          HDR_DIGITS   = 4;
    localparam int          LIMIT_CYCLES = 400000;    // many times the slowest correct run
    localparam int          DRAIN_CYCLES = 12;        // result register plus margin

    // Track the deframer state and queue the result that each stream byte
    // should cause, then match accepted results against that queue.
    class frame_scoreboard;

        typedef struct {
            kind_t             kind;
            logic [BYTE_W-1:0] data;
            logic              last;
        } frame_result_t;

        frame_result_t     pending_results[$];
        int                mismatches;
        int                results_seen;

        bit                in_body;
        int unsigned       digits_left;
        logic [LEN_W-1:0]  length_accum;
        bit                bad_digit_seen;
        logic [LEN_W-1:0]  body_left;
        bit                sticky_error;

        function new();
            mismatches     = 0;
            results_seen   = 0;
            body_left      = '0;
            sticky_error   = 1'b0;
            restart_header();
        endfunction

        function void restart_header();
            in_body        = 1'b0;
            digits_left    = HDR_DIGITS;
            length_accum   = '0;
            bad_digit_seen = 1'b0;
        endfunction

        function void push_result(kind_t kind, logic [BYTE_W-1:0] data, logic last);
            frame_result_t r;
            r.kind = kind;
            r.data = data;
            r.last = last;
            pending_results.push_back(r);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Advance the deframer state by one accepted stream byte.
        function void note_stream_byte(logic [BYTE_W-1:0] b);
            int unsigned acc;
            if (sticky_error) begin
                push_result(KIND_ERROR, '0, 1'b0);
                return;
            end
            if (in_body) begin
                push_result(KIND_BODY, b, body_left <= 1);
                if (body_left > 0)
                    body_left = body_left - 1'b1;
                if (body_left == 0)
                    restart_header();
                return;
            end
            if (b < CHAR_ZERO || b > CHAR_NINE) begin
                bad_digit_seen = 1'b1;
            end
            else begin
                acc = int'(length_accum) * 10 + int'(b - CHAR_ZERO);
                length_accum = (acc > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(acc);
            end
            if (digits_left > 0)
                digits_left--;
            if (digits_left != 0)
                return;
            if (bad_digit_seen) begin
                sticky_error = 1'b1;
                push_result(KIND_ERROR, '0, 1'b0);
            end
            else if (length_accum == 0) begin
                restart_header();
                push_result(KIND_EMPTY, '0, 1'b1);
            end
            else begin
                body_left    = length_accum;
                in_body      = 1'b1;
                digits_left  = HDR_DIGITS;
                length_accum = '0;
            end
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                     results_seen, what, got, want);
        endtask

        task check_result(logic [1:0] kind, logic [BYTE_W-1:0] data, logic last);
            frame_result_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report("unexpected result, kind", kind, 0);
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind)
                report("result_kind", kind, want.kind);
            if (data !== want.data)
                report("body_byte", data, want.data);
            if (last !== want.last)
                report("packet_end", last, want.last);
        endtask

    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        result_kind;
    logic [BYTE_W-1:0] body_byte;
    logic              packet_end;

    frame_scoreboard   sb;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                bytes_sent;
    int                cycle_count;

    decimal_length_prefix_deframer #(
        .HEADER_DIGITS(HDR_DIGITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_kind(result_kind),
        .body_byte  (body_byte),
        .packet_end (packet_end)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watch both channels at each edge. Values read here are the ones the
    // block saw at this edge; note the input transfer before checking the
    // output so the order within the step never matters. Then pick the next
    // stall of the receiver.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_stream_byte(in_byte);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_kind, body_byte, packet_end);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Present one byte, with random idle cycles first, and hold it until the
    // transfer. valid gets one assignment per step, so back-to-back bytes keep
    // it high.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Spell the length as HDR_DIGITS ASCII digits, most significant first.
    task automatic send_header(input int unsigned len);
        int unsigned scale;
        int unsigned digit;
        scale = 1;
        repeat (HDR_DIGITS - 1)
            scale = scale * 10;
        repeat (HDR_DIGITS) begin
            digit = (len / scale) % 10;
            send_byte(CHAR_ZERO + BYTE_W'(digit));
            scale = scale / 10;
        end
    endtask

    task automatic send_frame(input int unsigned len);
        send_header(len);
        repeat (len)
            send_byte(BYTE_W'($urandom_range(255)));
    endtask

    // Keep most bodies short; now and then reach into the hundreds digit.
    function automatic int unsigned pick_length();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 0;
        else if (pick < 70)
            return $urandom_range(8, 1);
        else if (pick < 95)
            return $urandom_range(60, 9);
        else
            return $urandom_range(400, 61);
    endfunction

    task automatic send_random_frames(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_frame(pick_length());
    endtask

    // Hold the sender until every queued result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Header with one non-digit at a random place; digits elsewhere. Values
    // just below '0' and just above '9' get a fair share.
    task automatic send_broken_header();
        int          bad_pos;
        logic [BYTE_W-1:0] bad_char;
        bad_pos = $urandom_range(HDR_DIGITS - 1);
        case ($urandom_range(3))
            0:       bad_char = CHAR_ZERO - 1'b1;
            1:       bad_char = CHAR_NINE + 1'b1;
            2:       bad_char = BYTE_W'($urandom_range(int'(CHAR_ZERO) - 1));
            default: bad_char = BYTE_W'($urandom_range(255, int'(CHAR_NINE) + 1));
        endcase
        for (int i = 0; i < HDR_DIGITS; i++) begin
            if (i == bad_pos)
                send_byte(bad_char);
            else
                send_byte(CHAR_ZERO + BYTE_W'($urandom_range(9)));
        end
    endtask

    // Abort a hung run.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        sb            = new();
        send_idle_pct = 37;
        recv_idle_pct = 77;
        bytes_sent    = 0;
        cycle_count   = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        out_stall <= 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty packet, one-byte body with 0x00, two-byte body with
        // 0xFF and a byte that looks like a header non-digit, then a three-byte body
        // of a non-digit, a digit and 0x80, and a second empty packet right after a body.
        send_header(0);
        send_header(1);
        send_byte(8'h00);
        send_header(2);
        send_byte(8'hFF);
        send_byte(CHAR_ZERO - 1'b1);
        send_header(3);
        send_byte(CHAR_NINE + 1'b1);
        send_byte(CHAR_ZERO + 8'd5);
        send_byte(8'h80);
        send_header(0);

        // Phase one: sender idles often, receiver stalls more.
        send_random_frames(450);
        wait_drained();

        // Phase two: swap the idling of the two sides.
        send_idle_pct = 77;
        recv_idle_pct = 37;
        send_random_frames(450);
        wait_drained();

        // Phase three: full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_frames(350);
        wait_drained();

        // Error tail under idling: a broken header, then noise that must all
        // come back as header errors.
        send_idle_pct = 37;
        recv_idle_pct = 77;
        send_broken_header();
        repeat (60)
            send_byte(BYTE_W'($urandom_range(255)));

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
